@@ src/tar_header_stream_walker_unit_assert.svh @@
// assertion macros for the tar header stream walker
`ifndef TAR_HEADER_STREAM_WALKER_UNIT_ASSERT_SVH
`define TAR_HEADER_STREAM_WALKER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsw assertion failed");
`define TSW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsw assertion failed");
`else
`define TSW_ASSERT_NOW(lbl, ante, cons)
`define TSW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/tsw_pkg.sv @@
// shared constants and types of the tar header stream walker
`timescale 1ns / 1ps
package tsw_pkg;
  localparam int DEF_PATH_MAX = 64;

  localparam logic [8:0] NAME_END   = 9'd100;
  localparam logic [8:0] SIZE_OFF   = 9'd124;
  localparam logic [8:0] SIZE_END   = 9'd136;
  localparam logic [8:0] TYPE_OFF   = 9'd156;
  localparam logic [8:0] PREFIX_OFF = 9'd345;
  localparam logic [8:0] PREFIX_END = 9'd500;
  localparam logic [8:0] HDR_LAST   = 9'd511;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] KIND_DIR  = 2'd0;
  localparam logic [1:0] KIND_FILE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [1:0] MODE_HDR  = 2'd0;
  localparam logic [1:0] MODE_SKIP = 2'd1;
  localparam logic [1:0] MODE_FIN  = 2'd2;

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_DIG  = 2'd1;
  localparam logic [1:0] PH_END  = 2'd2;
  localparam logic [1:0] PH_BAD  = 2'd3;

  localparam logic [3:0] REG_IMAGE_SIZE = 4'h0;

  typedef struct packed {
    logic fetch;
    logic emit;
    logic emit_last;
  } tsw_cmd_t;

  typedef struct packed {
    logic path_go;
    logic hdr_risk;
    logic out_vld;
    logic slot_free;
    logic ch_slash;
    logic ch_dot;
  } tsw_stat_t;
endpackage

@@ src/tsw_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/tsw_ctrl.sv @@
// path emission controller state machine
`timescale 1ns / 1ps
module tsw_ctrl import tsw_pkg::*; #(
  parameter int PATH_MAX = DEF_PATH_MAX
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tsw_stat_t                   stat,
  input  logic [$clog2(PATH_MAX)-1:0] raw_len,
  output tsw_cmd_t                    cmd,
  output logic [$clog2(PATH_MAX)-1:0] fetch_idx,
  output logic                        in_tready
);
  localparam int IW = $clog2(PATH_MAX);

  localparam logic [2:0] S_RUN    = 3'd0;
  localparam logic [2:0] S_LEAD_A = 3'd1;
  localparam logic [2:0] S_LEAD_B = 3'd2;
  localparam logic [2:0] S_LEAD_C = 3'd3;
  localparam logic [2:0] S_TRL_A  = 3'd4;
  localparam logic [2:0] S_TRL_B  = 3'd5;
  localparam logic [2:0] S_EMIT_A = 3'd6;
  localparam logic [2:0] S_EMIT_B = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] rd_r, rd_nxt, end_r, end_nxt, j_r, j_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      rd_r    <= '0;
      end_r   <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      rd_r    <= rd_nxt;
      end_r   <= end_nxt;
      j_r     <= j_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_nxt    = rd_r;
    end_nxt   = end_r;
    j_nxt     = j_r;
    cmd       = '0;
    fetch_idx = rd_r;
    in_tready = 1'b0;
    case (state_r)
      S_RUN: begin
        in_tready = !(stat.hdr_risk && stat.out_vld);
        if (stat.path_go) begin
          rd_nxt    = '0;
          state_nxt = S_LEAD_A;
        end
      end
      S_LEAD_A: begin
        if (rd_r >= raw_len) begin
          state_nxt = S_RUN;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = S_LEAD_B;
        end
      end
      S_LEAD_B: begin
        if (stat.ch_slash) begin
          rd_nxt    = rd_r + 1'b1;
          state_nxt = S_LEAD_A;
        end else if (stat.ch_dot) begin
          cmd.fetch = 1'b1;
          fetch_idx = rd_r + 1'b1;
          state_nxt = S_LEAD_C;
        end else begin
          end_nxt   = raw_len;
          state_nxt = S_TRL_A;
        end
      end
      S_LEAD_C: begin
        if (stat.ch_slash) begin
          rd_nxt    = rd_r + IW'(2);
          state_nxt = S_LEAD_A;
        end else begin
          end_nxt   = raw_len;
          state_nxt = S_TRL_A;
        end
      end
      S_TRL_A: begin
        if (end_r == rd_r) begin
          state_nxt = S_RUN;
        end else begin
          cmd.fetch = 1'b1;
          fetch_idx = end_r - 1'b1;
          state_nxt = S_TRL_B;
        end
      end
      S_TRL_B: begin
        if (stat.ch_slash) begin
          end_nxt   = end_r - 1'b1;
          state_nxt = S_TRL_A;
        end else begin
          j_nxt     = rd_r;
          state_nxt = S_EMIT_A;
        end
      end
      S_EMIT_A: begin
        cmd.fetch = 1'b1;
        fetch_idx = j_r;
        state_nxt = S_EMIT_B;
      end
      S_EMIT_B: begin
        fetch_idx = j_r;
        if (stat.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = (j_r + 1'b1) == end_r;
          j_nxt         = j_r + 1'b1;
          state_nxt     = cmd.emit_last ? S_RUN : S_EMIT_A;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end
endmodule

@@ src/tsw_dp.sv @@
// header parsing datapath, name stores and result register
`timescale 1ns / 1ps
module tsw_dp import tsw_pkg::*; #(
  parameter int PATH_MAX = DEF_PATH_MAX
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_accept,
  input  logic [7:0]                  in_byte,
  input  logic [39:0]                 img_bytes,
  input  tsw_cmd_t                    cmd,
  input  logic [$clog2(PATH_MAX)-1:0] fetch_idx,
  output tsw_stat_t                   stat,
  output logic [$clog2(PATH_MAX)-1:0] raw_len,
  output logic                        out_vld,
  input  logic                        out_rdy,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_char,
  output logic [35:0]                 out_size,
  output logic [39:0]                 out_off,
  output logic                        out_last
);
  localparam int IW = $clog2(PATH_MAX);

  logic [39:0] pos_r, pos_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [8:0]  hcnt_r, hcnt_nxt;
  logic [36:0] skip_r, skip_nxt;
  logic        nz_r, nz_nxt;
  logic [35:0] acc_r, acc_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [7:0]  typ_r, typ_nxt;
  logic [6:0]  nl_r, nl_nxt;
  logic [7:0]  pl_r, pl_nxt;

  logic        ov_r, ov_nxt, ol_r, ol_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [7:0]  oc_r, oc_nxt;
  logic [35:0] os_r, os_nxt;
  logic [39:0] oo_r, oo_nxt;

  logic        beyond_r, slash_r, pre_r;
  logic [7:0]  nram_q, pram_q, ch;

  logic        hdr0, room_fail, digit, blank, nz_b, type_ok, len_ok, err, go;
  logic [35:0] acc_b;
  logic [1:0]  ph_b;
  logic [6:0]  nl_b;
  logic [7:0]  pl_b;
  logic [39:0] posn;
  logic [8:0]  joined;
  logic [36:0] aligned;
  logic        n_we, p_we;
  logic [IW-1:0] n_raddr;

  assign hdr0      = hcnt_r == 9'd0;
  assign room_fail = hdr0 && (({1'b0, pos_r} + 41'd512) > {1'b0, img_bytes});
  assign digit     = in_byte >= CH_0 && in_byte <= CH_7;
  assign blank     = in_byte == CH_SPACE || in_byte == 8'd0;
  assign nz_b      = hdr0 ? 1'b0 : nz_r;
  assign acc_b     = hdr0 ? '0 : acc_r;
  assign ph_b      = hdr0 ? PH_LEAD : ph_r;
  assign nl_b      = hdr0 ? '0 : nl_r;
  assign pl_b      = hdr0 ? '0 : pl_r;
  assign posn      = pos_r + 40'd1;
  assign joined    = {1'b0, pl_r} + 9'd1 + {2'b0, nl_r};
  assign aligned   = ({1'b0, acc_r} + 37'd511) & ~37'd511;
  assign type_ok   = typ_r == CH_5 || typ_r == CH_0 || typ_r == 8'd0;
  assign len_ok    = nl_r != 7'd0 &&
                     ((pl_r == 8'd0) ? ({2'b0, nl_r} < 9'(PATH_MAX)) :
                      (({1'b0, pl_r} + 9'd1) < 9'(PATH_MAX) && joined < 9'(PATH_MAX)));
  assign raw_len   = (pl_r == 8'd0) ? IW'(nl_r) : IW'(joined);
  assign err       = ph_r == PH_BAD || posn > img_bytes ||
                     {4'b0, acc_r} > (img_bytes - posn);
  assign go        = in_accept && mode_r == MODE_HDR && !hdr0 && hcnt_r == HDR_LAST &&
                     (nz_r || in_byte != 8'd0) && !err && type_ok && len_ok;

  assign n_we = in_accept && mode_r == MODE_HDR && !room_fail && hcnt_r < NAME_END &&
                in_byte != 8'd0 && {2'b0, nl_b} == hcnt_r && nl_b < 7'(PATH_MAX);
  assign p_we = in_accept && mode_r == MODE_HDR && !room_fail && hcnt_r >= PREFIX_OFF &&
                hcnt_r < PREFIX_END && in_byte != 8'd0 &&
                {1'b0, pl_b} == (hcnt_r - PREFIX_OFF) && pl_b < 8'(PATH_MAX);
  assign n_raddr = (pl_r == 8'd0) ? fetch_idx : fetch_idx - IW'(pl_r) - 1'b1;

  tsw_ram #(.WIDTH(8), .DEPTH(PATH_MAX)) u_name (
    .clk(clk), .we(n_we), .waddr(nl_b[IW-1:0]), .wdata(in_byte),
    .raddr(n_raddr), .rdata(nram_q)
  );
  tsw_ram #(.WIDTH(8), .DEPTH(PATH_MAX)) u_prefix (
    .clk(clk), .we(p_we), .waddr(pl_b[IW-1:0]), .wdata(in_byte),
    .raddr(fetch_idx), .rdata(pram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      beyond_r <= fetch_idx >= raw_len;
      slash_r  <= pl_r != 8'd0 && {{(8 - IW){1'b0}}, fetch_idx} == pl_r;
      pre_r    <= pl_r != 8'd0 && {{(8 - IW){1'b0}}, fetch_idx} < pl_r;
    end
  end

  assign ch = beyond_r ? 8'd0 : slash_r ? CH_SLASH : pre_r ? pram_q : nram_q;

  assign stat.path_go   = go;
  assign stat.hdr_risk  = mode_r == MODE_HDR && (hdr0 || hcnt_r == HDR_LAST);
  assign stat.out_vld   = ov_r;
  assign stat.slot_free = !ov_r || out_rdy;
  assign stat.ch_slash  = ch == CH_SLASH;
  assign stat.ch_dot    = ch == CH_DOT;

  always_comb begin
    pos_nxt  = pos_r;
    mode_nxt = mode_r;
    hcnt_nxt = hcnt_r;
    skip_nxt = skip_r;
    nz_nxt   = nz_r;
    acc_nxt  = acc_r;
    ph_nxt   = ph_r;
    typ_nxt  = typ_r;
    nl_nxt   = nl_r;
    pl_nxt   = pl_r;
    ov_nxt   = ov_r && !out_rdy;
    ok_nxt   = ok_r;
    oc_nxt   = oc_r;
    os_nxt   = os_r;
    oo_nxt   = oo_r;
    ol_nxt   = ol_r;
    if (cmd.emit) begin
      ov_nxt = 1'b1;
      ok_nxt = (typ_r == CH_5) ? KIND_DIR : KIND_FILE;
      oc_nxt = ch;
      os_nxt = (typ_r == CH_5) ? '0 : acc_r;
      oo_nxt = (typ_r == CH_5) ? '0 : pos_r;
      ol_nxt = cmd.emit_last;
    end
    if (in_accept && (mode_r == MODE_HDR || mode_r == MODE_SKIP)) begin
      pos_nxt = posn;
      if (mode_r == MODE_SKIP) begin
        skip_nxt = (skip_r != '0) ? skip_r - 1'b1 : skip_r;
        if (skip_nxt == '0) begin
          mode_nxt = MODE_HDR;
        end
      end else if (room_fail) begin
        mode_nxt = MODE_FIN;
        ov_nxt   = 1'b1;
        ok_nxt   = KIND_DONE;
        oc_nxt   = '0;
        os_nxt   = '0;
        oo_nxt   = '0;
        ol_nxt   = 1'b1;
      end else begin
        nz_nxt  = nz_b || in_byte != 8'd0;
        acc_nxt = acc_b;
        ph_nxt  = ph_b;
        typ_nxt = hdr0 ? 8'd0 : typ_r;
        nl_nxt  = nl_b;
        pl_nxt  = pl_b;
        if (hcnt_r < NAME_END && in_byte != 8'd0 && {2'b0, nl_b} == hcnt_r) begin
          nl_nxt = nl_b + 1'b1;
        end
        if (hcnt_r >= SIZE_OFF && hcnt_r < SIZE_END) begin
          if (ph_b == PH_LEAD) begin
            if (digit) begin
              acc_nxt = {33'b0, in_byte[2:0]};
              ph_nxt  = PH_DIG;
            end else if (!blank) begin
              ph_nxt = PH_BAD;
            end
          end else if (ph_b == PH_DIG) begin
            if (digit) begin
              acc_nxt = {acc_b[32:0], in_byte[2:0]};
            end else begin
              ph_nxt = blank ? PH_END : PH_BAD;
            end
          end
        end
        if (hcnt_r == TYPE_OFF) begin
          typ_nxt = in_byte;
        end
        if (hcnt_r >= PREFIX_OFF && hcnt_r < PREFIX_END && in_byte != 8'd0 &&
            {1'b0, pl_b} == (hcnt_r - PREFIX_OFF)) begin
          pl_nxt = pl_b + 1'b1;
        end
        hcnt_nxt = hcnt_r + 1'b1;
        if (hcnt_r == HDR_LAST) begin
          if (!nz_nxt || err) begin
            mode_nxt = MODE_FIN;
            ov_nxt   = 1'b1;
            ok_nxt   = nz_nxt ? KIND_ERR : KIND_DONE;
            oc_nxt   = '0;
            os_nxt   = '0;
            oo_nxt   = '0;
            ol_nxt   = 1'b1;
          end else if (aligned != '0) begin
            skip_nxt = aligned;
            mode_nxt = MODE_SKIP;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mode_r <= MODE_HDR;
      hcnt_r <= '0;
      skip_r <= '0;
      nz_r   <= 1'b0;
      acc_r  <= '0;
      ph_r   <= PH_LEAD;
      typ_r  <= '0;
      nl_r   <= '0;
      pl_r   <= '0;
      ov_r   <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      mode_r <= mode_nxt;
      hcnt_r <= hcnt_nxt;
      skip_r <= skip_nxt;
      nz_r   <= nz_nxt;
      acc_r  <= acc_nxt;
      ph_r   <= ph_nxt;
      typ_r  <= typ_nxt;
      nl_r   <= nl_nxt;
      pl_r   <= pl_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
    oc_r <= oc_nxt;
    os_r <= os_nxt;
    oo_r <= oo_nxt;
    ol_r <= ol_nxt;
  end

  assign out_vld  = ov_r;
  assign out_kind = ok_r;
  assign out_char = oc_r;
  assign out_size = os_r;
  assign out_off  = oo_r;
  assign out_last = ol_r;
endmodule

@@ src/tar_header_stream_walker_unit.sv @@
// tar header stream walker top level
// a done or error result appears in the cycle after the byte that causes it
// throughput: one archive byte per cycle, stalled by path output or unread result
// path output: follows a header's last byte, with input held meanwhile
// the path scan reads the name and prefix stores, each with one registered read port
// reset: synchronous active-low, clears walk state, image size and result valid
`timescale 1ns / 1ps
`include "tar_header_stream_walker_unit_assert.svh"
module tar_header_stream_walker_unit import tsw_pkg::*; #(
  parameter int PATH_MAX = DEF_PATH_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // archive_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,   // path_char, entry_size, data_offset, zero pad
  output logic [1:0]  out_tuser,   // entry_kind
  output logic        out_tlast,   // last_char
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int IW = $clog2(PATH_MAX);

  logic [39:0]   img_r;
  tsw_cmd_t      cmd;
  tsw_stat_t     stat;
  logic [IW-1:0] fetch_idx, raw_len;
  logic [7:0]    o_char;
  logic [35:0]   o_size;
  logic [39:0]   o_off;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_IMAGE_SIZE) ? {24'b0, img_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_IMAGE_SIZE) begin
      img_r <= cfg_pwdata[39:0];
    end
  end

  tsw_ctrl #(.PATH_MAX(PATH_MAX)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .stat(stat), .raw_len(raw_len),
    .cmd(cmd), .fetch_idx(fetch_idx), .in_tready(in_tready)
  );

  tsw_dp #(.PATH_MAX(PATH_MAX)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_accept(in_tvalid && in_tready), .in_byte(in_tdata),
    .img_bytes(img_r), .cmd(cmd), .fetch_idx(fetch_idx), .stat(stat),
    .raw_len(raw_len), .out_vld(out_tvalid), .out_rdy(out_tready),
    .out_kind(out_tuser), .out_char(o_char), .out_size(o_size), .out_off(o_off),
    .out_last(out_tlast)
  );

  assign out_tdata = {4'b0, o_off, o_size, o_char};

  `TSW_ASSERT_NOW(a_end_is_last, out_tvalid && out_tuser[1], out_tlast)
  `TSW_ASSERT_NOW(a_end_is_blank, out_tvalid && out_tuser[1], out_tdata == '0)
  `TSW_ASSERT_NOW(a_dir_no_size, out_tvalid && out_tuser == KIND_DIR, out_tdata[87:8] == '0)
  `TSW_ASSERT_NEXT(a_hold_during_path, cmd.fetch, !in_tready)
endmodule
